// ----- rtl/ncrd_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the nested count record deframer
package ncrd_pkg;

    localparam int unsigned MIN_MESSAGE = 8;
    localparam int unsigned FIELD_BYTES = 4;
    localparam int unsigned RES_DEPTH   = 4;
    localparam int unsigned RES_AW      = 2;

    typedef enum logic [7:0] {
        PH_TICK    = 8'b0000_0001,
        PH_GCOUNT  = 8'b0000_0010,
        PH_TAG     = 8'b0000_0100,
        PH_RCOUNT  = 8'b0000_1000,
        PH_ENTITY  = 8'b0001_0000,
        PH_SIZE    = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_IDLE    = 8'b1000_0000
    } t_phase;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        logic        kind;
        logic [31:0] entity_id;
        logic [31:0] type_tag;
        logic [7:0]  payload_byte;
        logic        record_first;
        logic        record_last;
        logic        message_ok;
    } t_result;

    // results produced by one accepted byte, packed toward slot 0
    typedef struct packed {
        logic [1:0] count;
        t_result    slot0;
        t_result    slot1;
    } t_push;

    typedef struct packed {
        logic [RES_AW:0] count;
    } t_fifo_stat;

endpackage

// ----- rtl/ncrd_if.sv -----
`timescale 1ns / 1ps
// valid/ready channels for message bytes and results
interface ncrd_in_if #(
    parameter int LENGTH_WIDTH = 24
);
    logic                    valid;
    logic                    ready;
    logic [7:0]              data_byte;
    logic [LENGTH_WIDTH-1:0] message_length;
    logic                    start_of_message;

    modport source (output valid, data_byte, message_length, start_of_message,
                    input ready);
    modport sink   (input valid, data_byte, message_length, start_of_message,
                    output ready);
endinterface

interface ncrd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] entity_id;
    logic [31:0] type_tag;
    logic [7:0]  payload_byte;
    logic        record_first;
    logic        record_last;
    logic        message_ok;

    modport source (output valid, kind, entity_id, type_tag, payload_byte, record_first,
                    record_last, message_ok, input ready);
    modport sink   (input valid, kind, entity_id, type_tag, payload_byte, record_first,
                    record_last, message_ok, output ready);
endinterface

// ----- rtl/ncrd_parse.sv -----
`timescale 1ns / 1ps
// byte parser: field assembly, nesting counters and result generation
module ncrd_parse #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [7:0]              i_data_byte,
    input  logic [LENGTH_WIDTH-1:0] i_message_length,
    input  logic                    i_start_of_message,
    output ncrd_pkg::t_push         o_push
);
    import ncrd_pkg::*;

    localparam int LW = LENGTH_WIDTH;

    logic [LW-1:0] r_pos,     n_pos,     e_pos;
    t_phase        r_phase,   n_phase,   e_phase;
    logic [31:0]   r_acc,     n_acc,     e_acc;
    logic [1:0]    r_cnt,     n_cnt,     e_cnt;
    logic [31:0]   r_groups,  n_groups,  e_groups;
    logic [31:0]   r_records, n_records, e_records;
    logic [31:0]   r_tag,     n_tag,     e_tag;
    logic [31:0]   r_entity,  n_entity,  e_entity;
    logic [31:0]   r_left,    n_left,    e_left;
    logic          r_deliver, n_deliver, e_deliver;

    logic [LW:0]   next_pos;
    logic [31:0]   acc_new;
    logic [33:0]   fit_sum;
    logic          have_pay;
    logic          have_stat;
    t_result       pay_res;
    t_result       stat_res;

    function automatic t_phase f_after_group(input logic [31:0] groups);
        return (groups != 32'd0) ? PH_TAG : PH_IDLE;
    endfunction

    always_comb begin
        // a start byte drops whatever message was in progress
        e_pos     = i_start_of_message ? '0 : r_pos;
        e_phase   = i_start_of_message ? PH_TICK : r_phase;
        e_acc     = i_start_of_message ? '0 : r_acc;
        e_cnt     = i_start_of_message ? '0 : r_cnt;
        e_groups  = i_start_of_message ? '0 : r_groups;
        e_records = i_start_of_message ? '0 : r_records;
        e_tag     = i_start_of_message ? '0 : r_tag;
        e_entity  = i_start_of_message ? '0 : r_entity;
        e_left    = i_start_of_message ? '0 : r_left;
        e_deliver = i_start_of_message ? 1'b0 : r_deliver;

        n_pos     = e_pos;
        n_phase   = e_phase;
        n_acc     = e_acc;
        n_cnt     = e_cnt;
        n_groups  = e_groups;
        n_records = e_records;
        n_tag     = e_tag;
        n_entity  = e_entity;
        n_left    = e_left;
        n_deliver = e_deliver;

        next_pos  = {1'b0, e_pos} + {{LW{1'b0}}, 1'b1};
        acc_new   = e_acc | ({24'd0, i_data_byte} << {e_cnt, 3'b000});
        fit_sum   = {{(33 - LW){1'b0}}, next_pos} + {2'b00, acc_new};
        have_pay  = 1'b0;
        pay_res   = '0;
        pay_res.kind = KIND_PAYLOAD;

        case (e_phase)
            PH_PAYLOAD: begin
                if (e_deliver) begin
                    have_pay             = 1'b1;
                    pay_res.entity_id    = e_entity;
                    pay_res.type_tag     = e_tag;
                    pay_res.payload_byte = i_data_byte;
                    pay_res.record_first = (e_left == e_acc);
                    pay_res.record_last  = (e_left == 32'd1);
                end
                n_left = e_left - 32'd1;
                if (n_left == 32'd0) begin
                    n_acc     = '0;
                    n_deliver = 1'b0;
                    n_records = e_records - 32'd1;
                    n_phase   = (n_records != 32'd0) ? PH_ENTITY : f_after_group(e_groups);
                end
            end
            PH_IDLE: begin
                n_acc = e_acc;
            end
            default: begin
                if (e_cnt == 2'(FIELD_BYTES - 1)) begin
                    n_acc = '0;
                    n_cnt = '0;
                    case (e_phase)
                        PH_TICK: begin
                            n_phase = PH_GCOUNT;
                        end
                        PH_GCOUNT: begin
                            n_groups = acc_new;
                            n_phase  = f_after_group(acc_new);
                        end
                        PH_TAG: begin
                            n_tag   = acc_new;
                            n_phase = PH_RCOUNT;
                        end
                        PH_RCOUNT: begin
                            n_groups  = e_groups - 32'd1;
                            n_records = acc_new;
                            n_phase   = (acc_new == 32'd0) ? f_after_group(n_groups)
                                                           : PH_ENTITY;
                        end
                        PH_ENTITY: begin
                            n_entity = acc_new;
                            n_phase  = PH_SIZE;
                        end
                        default: begin
                            // size field: zero closes the record at once
                            if (acc_new == 32'd0) begin
                                n_deliver = 1'b0;
                                n_left    = '0;
                                n_records = e_records - 32'd1;
                                n_phase   = (n_records != 32'd0) ? PH_ENTITY
                                                                 : f_after_group(e_groups);
                            end else begin
                                n_left    = acc_new;
                                n_acc     = acc_new;
                                n_deliver = (fit_sum <= {{(34 - LW){1'b0}}, i_message_length});
                                n_phase   = PH_PAYLOAD;
                            end
                        end
                    endcase
                end else begin
                    n_acc = acc_new;
                    n_cnt = e_cnt + 2'd1;
                end
            end
        endcase

        have_stat           = (next_pos >= {1'b0, i_message_length});
        stat_res            = '0;
        stat_res.kind       = KIND_STATUS;
        stat_res.message_ok = ({1'b0, i_message_length} >= (LW + 1)'(MIN_MESSAGE));

        if (have_stat) begin
            n_pos     = '0;
            n_phase   = PH_TICK;
            n_acc     = '0;
            n_cnt     = '0;
            n_groups  = '0;
            n_records = '0;
            n_tag     = '0;
            n_entity  = '0;
            n_left    = '0;
            n_deliver = 1'b0;
        end else begin
            n_pos = next_pos[LW-1:0];
        end

        o_push.count = {1'b0, have_pay} + {1'b0, have_stat};
        o_push.slot0 = have_pay ? pay_res : stat_res;
        o_push.slot1 = stat_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_phase   <= PH_TICK;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_groups  <= '0;
            r_records <= '0;
            r_tag     <= '0;
            r_entity  <= '0;
            r_left    <= '0;
            r_deliver <= 1'b0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_groups  <= n_groups;
            r_records <= n_records;
            r_tag     <= n_tag;
            r_entity  <= n_entity;
            r_left    <= n_left;
            r_deliver <= n_deliver;
        end
    end

endmodule

// ----- rtl/ncrd_fifo.sv -----
`timescale 1ns / 1ps
// result queue taking up to two results per cycle and giving one
module ncrd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_en,
    input  ncrd_pkg::t_push      i_push,
    input  logic                 i_pop,
    output ncrd_pkg::t_result    o_head,
    output ncrd_pkg::t_fifo_stat o_stat
);
    import ncrd_pkg::*;

    t_result           r_mem [RES_DEPTH];
    logic [RES_AW-1:0] r_head, n_head;
    logic [RES_AW-1:0] r_tail, n_tail;
    logic [RES_AW:0]   r_count, n_count;
    logic [1:0]        push_n;

    always_comb begin
        push_n  = i_push_en ? i_push.count : 2'd0;
        n_head  = r_head + RES_AW'(i_pop);
        n_tail  = r_tail + RES_AW'(push_n);
        n_count = r_count + (RES_AW + 1)'(push_n) - (RES_AW + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_tail] <= i_push.slot0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_tail + RES_AW'(1)] <= i_push.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_head       = r_mem[r_head];
    assign o_stat.count = r_count;

endmodule

// ----- rtl/nested_count_record_deframer_unit.sv -----
`timescale 1ns / 1ps
// Nested count record deframer: takes one message byte per cycle while the result
// queue has room, assembles the little-endian header, group and record fields,
// and emits each payload byte of a record that fits the message, tagged with its
// entity and type, plus one status result after the last byte of every message.
// A byte is parsed in the cycle it is accepted; its results (at most two) land in
// a four-entry result queue and appear on the output from the next cycle on.
// Input is taken every cycle while the queue has two free entries, so the
// sustained byte rate is set by the output side, which gives one result per cycle while the receiver is ready.
module nested_count_record_deframer_unit #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ncrd_in_if.sink     i_in,
    ncrd_out_if.source  o_out
);
    import ncrd_pkg::*;

    t_push      push;
    t_result    head;
    t_fifo_stat fifo_stat;
    logic       in_fire;
    logic       out_pop;

    assign i_in.ready = (fifo_stat.count <= (RES_AW + 1)'(RES_DEPTH - 2));
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_pop    = o_out.valid && o_out.ready;

    ncrd_parse #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (in_fire),
        .i_data_byte        (i_in.data_byte),
        .i_message_length   (i_in.message_length),
        .i_start_of_message (i_in.start_of_message),
        .o_push             (push)
    );

    ncrd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (in_fire),
        .i_push    (push),
        .i_pop     (out_pop),
        .o_head    (head),
        .o_stat    (fifo_stat)
    );

    assign o_out.valid        = (fifo_stat.count != '0);
    assign o_out.kind         = head.kind;
    assign o_out.entity_id    = head.entity_id;
    assign o_out.type_tag     = head.type_tag;
    assign o_out.payload_byte = head.payload_byte;
    assign o_out.record_first = head.record_first;
    assign o_out.record_last  = head.record_last;
    assign o_out.message_ok   = head.message_ok;

`ifndef ASSERT_OFF
    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.count <= (RES_AW + 1)'(RES_DEPTH))
        else $error("result queue overfilled");

    a_room_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> fifo_stat.count <= (RES_AW + 1)'(RES_DEPTH - 2))
        else $error("byte accepted without room for its results");

    a_status_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_STATUS) |->
            (o_out.entity_id == '0 && o_out.type_tag == '0 && o_out.payload_byte == '0
             && !o_out.record_first && !o_out.record_last))
        else $error("status result carries payload fields");

    a_payload_no_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_PAYLOAD) |-> !o_out.message_ok)
        else $error("payload result carries message status");
`endif

endmodule
